@@ hw/rtl/utd_pkg.sv @@
// ----------------------------------------------------------------------------
// utd_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package utd_pkg;

  // byte classes of the UTF-8 lead byte
  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD3_SURR  = 8'hED;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;

  // limits on the second byte of a sequence
  localparam logic [7:0] CONT_A0     = 8'hA0;
  localparam logic [7:0] CONT_9F     = 8'h9F;
  localparam logic [7:0] CONT_90     = 8'h90;
  localparam logic [7:0] CONT_8F     = 8'h8F;

  // surrogate pair construction
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [15:0] HIGH_SURR  = 16'hD800;
  localparam logic [15:0] LOW_SURR   = 16'hDC00;

  // restriction on the next continuation byte
  typedef enum logic [2:0] {
    RULE_NONE,
    RULE_MIN_A0,
    RULE_MAX_9F,
    RULE_MIN_90,
    RULE_MAX_8F
  } rule_t;

  // work handed from the front to the back: one byte's results
  typedef struct packed {
    logic [20:0] cp;    // code point, zero on error
    logic        pair;  // emit as a surrogate pair
    logic        done;  // final result of the text
    logic        err;   // text was invalid
  } task_t;

endpackage

@@ hw/rtl/utd_front.sv @@
// ----------------------------------------------------------------------------
// utd_front
// Byte-level UTF-8 validator and code point assembler; one byte per cycle while accept is high.
// ----------------------------------------------------------------------------
module utd_front import utd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wide,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output logic       push,
  output task_t      push_task
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] part_r, part_nxt;
  rule_t       rule_r, rule_nxt;
  logic        disc_r, disc_nxt;

  logic        bad;
  logic        emit;
  logic        rule_ok;
  logic [20:0] cp;
  logic [20:0] shifted;

  // second byte limits
  always_comb begin
    unique case (rule_r)
      RULE_NONE:   rule_ok = 1'b1;
      RULE_MIN_A0: rule_ok = (byte_in >= CONT_A0);
      RULE_MAX_9F: rule_ok = (byte_in <= CONT_9F);
      RULE_MIN_90: rule_ok = (byte_in >= CONT_90);
      RULE_MAX_8F: rule_ok = (byte_in <= CONT_8F);
      default:     rule_ok = 1'b1;
    endcase
  end

  // decode one byte against the current sequence state
  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    rule_nxt = rule_r;
    disc_nxt = disc_r;
    bad      = 1'b0;
    emit     = 1'b0;
    cp       = {13'd0, byte_in};
    shifted  = {part_r[14:0], byte_in[5:0]};

    if (disc_r) begin
      bad = 1'b1;
    end else if (pend_r == 2'd0) begin
      unique case (byte_in) inside
        [8'h00:ASCII_MAX]: begin
          emit = 1'b1;
        end
        [LEAD2_MIN:LEAD2_MAX]: begin
          pend_nxt = 2'd1;
          part_nxt = {16'd0, byte_in[4:0]};
          rule_nxt = RULE_NONE;
        end
        [LEAD3_MIN:LEAD3_MAX]: begin
          pend_nxt = 2'd2;
          part_nxt = {17'd0, byte_in[3:0]};
          rule_nxt = (byte_in == LEAD3_MIN)  ? RULE_MIN_A0 :
                     (byte_in == LEAD3_SURR) ? RULE_MAX_9F : RULE_NONE;
        end
        [LEAD4_MIN:LEAD4_MAX]: begin
          pend_nxt = 2'd3;
          part_nxt = {18'd0, byte_in[2:0]};
          rule_nxt = (byte_in == LEAD4_MIN) ? RULE_MIN_90 :
                     (byte_in == LEAD4_MAX) ? RULE_MAX_8F : RULE_NONE;
        end
        default: begin
          bad = 1'b1;
        end
      endcase
    end else begin
      if ((byte_in[7:6] != 2'b10) || !rule_ok) begin
        bad = 1'b1;
      end else begin
        rule_nxt = RULE_NONE;
        part_nxt = shifted;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          emit     = 1'b1;
          cp       = shifted;
          part_nxt = '0;
        end
      end
    end

    // end of text inside a sequence counts as an error
    if (!emit && last_in) begin
      bad = 1'b1;
    end

    if (bad) begin
      pend_nxt = 2'd0;
      part_nxt = '0;
      rule_nxt = RULE_NONE;
      disc_nxt = !last_in;
    end else if (emit) begin
      rule_nxt = RULE_NONE;
    end
  end

  // task for the back end
  always_comb begin
    push           = accept && (emit || bad) && (emit || last_in);
    push_task.cp   = bad ? 21'd0 : cp;
    push_task.pair = !bad && !wide && (cp[20:16] != 5'd0);
    push_task.done = last_in;
    push_task.err  = bad;
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      part_r <= '0;
      rule_r <= RULE_NONE;
      disc_r <= 1'b0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      rule_r <= rule_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

@@ hw/rtl/utd_queue.sv @@
// ----------------------------------------------------------------------------
// utd_queue
// Small register queue of tasks between the front and the back.
// ----------------------------------------------------------------------------
module utd_queue import utd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  task_t push_task,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output task_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  task_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_task;
    end
  end

endmodule

@@ hw/rtl/utd_back.sv @@
// ----------------------------------------------------------------------------
// utd_back
// Expands tasks into code units and holds them in the output register.
// ----------------------------------------------------------------------------
module utd_back import utd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        empty,
  input  task_t       head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_unit,
  output logic        out_item_last,
  output logic        out_done,
  output logic        out_err
);

  logic        valid_r, valid_nxt;
  logic        phase_r, phase_nxt;
  logic [20:0] unit_r, unit_nxt;
  logic        item_last_r, item_last_nxt;
  logic        done_r, done_nxt;
  logic        err_r, err_nxt;

  logic        load;
  logic [20:0] payload;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;

  assign load    = !valid_r || out_ready;
  assign payload = head.cp - SUPP_BASE;
  assign hi_unit = HIGH_SURR + {6'd0, payload[19:10]};
  assign lo_unit = LOW_SURR | {6'd0, head.cp[9:0]};

  // next output and queue pop
  always_comb begin
    valid_nxt     = valid_r;
    phase_nxt     = phase_r;
    unit_nxt      = unit_r;
    item_last_nxt = item_last_r;
    done_nxt      = done_r;
    err_nxt       = err_r;
    pop           = 1'b0;
    if (load) begin
      valid_nxt = !empty;
      if (!empty) begin
        err_nxt = head.err;
        if (!head.pair) begin
          unit_nxt      = head.cp;
          item_last_nxt = 1'b1;
          done_nxt      = head.done;
          pop           = 1'b1;
        end else if (!phase_r) begin
          unit_nxt      = {5'd0, hi_unit};
          item_last_nxt = 1'b0;
          done_nxt      = 1'b0;
          phase_nxt     = 1'b1;
        end else begin
          unit_nxt      = {5'd0, lo_unit};
          item_last_nxt = 1'b1;
          done_nxt      = head.done;
          phase_nxt     = 1'b0;
          pop           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r      <= unit_nxt;
    item_last_r <= item_last_nxt;
    done_r      <= done_nxt;
    err_r       <= err_nxt;
  end

  assign out_valid     = valid_r;
  assign out_unit      = unit_r;
  assign out_item_last = item_last_r;
  assign out_done      = done_r;
  assign out_err       = err_r;

endmodule

@@ hw/rtl/utf8_to_utf16_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder
// Strict UTF-8 to UTF-16 (or 21-bit code point) stream decoder.
// ----------------------------------------------------------------------------
//  channel | signals                       | contents
//  --------+-------------------------------+---------------------------------
//  in      | in_tvalid/in_tready           | tdata[7:0] byte, tlast end of text
//  out     | out_tvalid/out_tready         | tdata[20:0] unit, [21] last of byte
//          |                               | tlast text done, tuser error
//  cfg     | cfg_valid/cfg_ready           | cfg_data: 1 = whole code points
//
//  one byte per cycle is accepted while the queue has room; a byte that
//  completes a supplementary code point in UTF-16 mode gives two units.
//  the front takes bytes whenever the task queue has room; the back drains
//  the queue into the output register, so each side stalls on its own.
//  reset is synchronous, active low, and leaves the block ready at once.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder import utd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_unit, [21] last_of_item
  output logic        out_tlast,
  output logic        out_tuser,  // [0] error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic        wide_r;
  logic        accept;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  task_t       push_task;
  task_t       head;
  logic [20:0] unit;
  logic        item_last;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      wide_r <= cfg_data;
    end
  end

  // input transfer
  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  utd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .wide      (wide_r),
    .accept    (accept),
    .byte_in   (in_tdata),
    .last_in   (in_tlast),
    .push      (push),
    .push_task (push_task)
  );

  utd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_task (push_task),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head      (head)
  );

  utd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_unit      (unit),
    .out_item_last (item_last),
    .out_done      (out_tlast),
    .out_err       (out_tuser)
  );

  // output packing
  assign out_tdata = {2'b00, item_last, unit};

`ifndef SYNTHESIS
  // an error result carries no code and closes both the byte and the text
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (unit == 21'd0 && item_last && out_tlast))
    else $error("error result with code or without end marks");

  // the end of the text is always the last result of its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> item_last)
    else $error("text end on a non-final unit");

  // in UTF-16 mode every unit fits in 16 bits
  a_narrow_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !wide_r) |-> (unit[20:16] == 5'd0))
    else $error("unit wider than 16 bits in UTF-16 mode");

  // a first surrogate half is followed by its low half
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !item_last) |=>
      (out_tvalid && item_last && unit[15:10] == LOW_SURR[15:10]))
    else $error("high surrogate not followed by low surrogate");
`endif

endmodule

@@ bench/tb_utf8_to_utf16_decoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_decoder
// Self-checking bench for the strict UTF-8 to UTF-16 stream decoder. Texts
// of well-formed, broken and random bytes are sent through the input
// channel, a behavioural decoder in the bench predicts every output unit,
// and the monitor compares each output transfer against the oldest
// prediction. Both output modes are run with and without back-pressure.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_decoder import utd_pkg::*; ();

  // one byte of a text waiting to be sent
  typedef struct packed {
    logic [7:0] value;
    logic       eot;
  } text_byte_t;

  // one predicted output unit
  typedef struct packed {
    logic [20:0] code;
    logic        last_of_byte;
    logic        text_done;
    logic        err;
  } utf16_unit_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] byte_value
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [20:0] code_unit, [21] last_of_item
  logic        out_tlast;
  logic        out_tuser;       // [0] error
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  // stimulus and prediction stores
  text_byte_t  text_bytes_q[$];
  utf16_unit_t utf16_units_q[$];

  // decoder state mirrored by the bench
  logic [1:0]  pend_cnt = '0;
  logic [20:0] acc_cp = '0;
  rule_t       next_rule = RULE_NONE;
  logic        drop_mode = 1'b0;
  logic        wide_mode = 1'b0;

  // traffic shaping
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  // bookkeeping
  int unsigned bytes_pushed = 0;
  int unsigned bytes_accepted = 0;
  int unsigned n_texts = 0;
  int unsigned n_units = 0;
  int unsigned n_pairs = 0;
  int unsigned n_err_results = 0;
  int unsigned n_fail = 0;

  utf8_to_utf16_decoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // append one predicted unit
  task automatic add_unit(input logic [20:0] code, input logic last_of_byte,
                          input logic text_done, input logic err);
    utf16_units_q.insert(utf16_units_q.size(),
                         utf16_unit_t'{code, last_of_byte, text_done, err});
  endtask

  // output of one decoded code point, as one unit or a surrogate pair
  task automatic emit_cp(input logic [20:0] cp, input logic eot);
    logic [20:0] payload;
    if (wide_mode || cp <= 21'h00FFFF) begin
      add_unit(cp, 1'b1, eot, 1'b0);
    end else begin
      payload = cp - SUPP_BASE;
      add_unit(21'(HIGH_SURR) + 21'(payload[19:10]), 1'b0, 1'b0, 1'b0);
      add_unit(21'(LOW_SURR) + 21'(payload[9:0]), 1'b1, eot, 1'b0);
    end
  endtask

  // behavioural decoder: one accepted byte in, predicted units out
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic        bad;
    logic        got;
    logic [20:0] cp;
    bad = 1'b0;
    got = 1'b0;
    cp  = '0;
    if (drop_mode) begin
      bad = 1'b1;
    end else if (pend_cnt == 2'd0) begin
      if (b <= ASCII_MAX) begin
        cp  = 21'(b);
        got = 1'b1;
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        pend_cnt  = 2'd1;
        acc_cp    = 21'(b[4:0]);
        next_rule = RULE_NONE;
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        pend_cnt  = 2'd2;
        acc_cp    = 21'(b[3:0]);
        next_rule = (b == LEAD3_MIN) ? RULE_MIN_A0 :
                    (b == LEAD3_SURR) ? RULE_MAX_9F : RULE_NONE;
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        pend_cnt  = 2'd3;
        acc_cp    = 21'(b[2:0]);
        next_rule = (b == LEAD4_MIN) ? RULE_MIN_90 :
                    (b == LEAD4_MAX) ? RULE_MAX_8F : RULE_NONE;
      end else begin
        bad = 1'b1;
      end
    end else if (b[7:6] != 2'b10) begin
      bad = 1'b1;
    end else if ((next_rule == RULE_MIN_A0 && b < CONT_A0) ||
                 (next_rule == RULE_MAX_9F && b > CONT_9F) ||
                 (next_rule == RULE_MIN_90 && b < CONT_90) ||
                 (next_rule == RULE_MAX_8F && b > CONT_8F)) begin
      bad = 1'b1;
    end else begin
      next_rule = RULE_NONE;
      acc_cp    = {acc_cp[14:0], b[5:0]};
      pend_cnt  = pend_cnt - 2'd1;
      if (pend_cnt == 2'd0) begin
        cp     = acc_cp;
        acc_cp = '0;
        got    = 1'b1;
      end
    end
    // a sequence left open by the end of the text is an error too
    if (!bad && !got && eot) bad = 1'b1;
    if (bad) begin
      pend_cnt  = 2'd0;
      acc_cp    = '0;
      next_rule = RULE_NONE;
      drop_mode = !eot;
      if (eot) add_unit(21'd0, 1'b1, 1'b1, 1'b1);
    end else if (got) begin
      emit_cp(cp, eot);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eot);
    text_bytes_q.insert(text_bytes_q.size(), text_byte_t'{b, eot});
    bytes_pushed++;
  endtask

  // utf-8 encoding of a valid code point
  task automatic push_cp(input logic [20:0] cp, input logic eot);
    if (cp < 21'h80) begin
      push_byte(cp[7:0], eot);
    end else if (cp < 21'h800) begin
      push_byte({3'b110, cp[10:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, eot);
    end else if (cp < 21'h10000) begin
      push_byte({4'b1110, cp[15:12]}, 1'b0);
      push_byte({2'b10, cp[11:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, eot);
    end else begin
      push_byte({5'b11110, cp[20:18]}, 1'b0);
      push_byte({2'b10, cp[17:12]}, 1'b0);
      push_byte({2'b10, cp[11:6]}, 1'b0);
      push_byte({2'b10, cp[5:0]}, eot);
    end
  endtask

  // random scalar value, boundaries now and then
  function automatic logic [20:0] rand_cp();
    logic [20:0] cp;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 9))
        0: cp = 21'h0;
        1: cp = 21'h7F;
        2: cp = 21'h80;
        3: cp = 21'h7FF;
        4: cp = 21'h800;
        5: cp = 21'hD7FF;
        6: cp = 21'hE000;
        7: cp = 21'hFFFF;
        8: cp = 21'h10000;
        default: cp = 21'h10FFFF;
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: cp = 21'($urandom_range(0, 'h7F));
        1: cp = 21'($urandom_range('h80, 'h7FF));
        2: begin
          do cp = 21'($urandom_range('h800, 'hFFFF));
          while (cp >= 21'hD800 && cp <= 21'hDFFF);
        end
        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
    end
    return cp;
  endfunction

  // one ill-formed sequence; ended is set when it closes the text itself
  task automatic push_broken(output bit ended);
    logic [7:0] lead;
    int         keep;
    ended = 1'b0;
    case ($urandom_range(0, 5))
      0: push_byte($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1))
                                        : 8'($urandom_range('hF5, 'hFF)), 1'b0);
      1: begin
        push_byte(8'($urandom_range('hC2, 'hF4)), 1'b0);
        push_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F))
                                       : 8'($urandom_range('hC0, 'hFF)), 1'b0);
      end
      2: begin
        // overlong three and four byte forms
        if ($urandom_range(0, 1)) begin
          push_byte(LEAD3_MIN, 1'b0);
          push_byte(8'($urandom_range('h80, 'h9F)), 1'b0);
        end else begin
          push_byte(LEAD4_MIN, 1'b0);
          push_byte(8'($urandom_range('h80, 'h8F)), 1'b0);
        end
      end
      3: begin
        push_byte(LEAD3_SURR, 1'b0);
        push_byte(8'($urandom_range('hA0, 'hBF)), 1'b0);
      end
      4: begin
        push_byte(LEAD4_MAX, 1'b0);
        push_byte(8'($urandom_range('h90, 'hBF)), 1'b0);
      end
      default: begin
        // truncated by the end of the text
        case ($urandom_range(0, 2))
          0: begin lead = 8'($urandom_range('hC2, 'hDF)); keep = 0; end
          1: begin lead = 8'($urandom_range('hE1, 'hEC)); keep = $urandom_range(0, 1); end
          default: begin lead = 8'($urandom_range('hF1, 'hF3)); keep = $urandom_range(0, 2); end
        endcase
        push_byte(lead, keep == 0);
        for (int i = 0; i < keep; i++)
          push_byte(8'($urandom_range('h80, 'hBF)), i == keep - 1);
        ended = 1'b1;
      end
    endcase
  endtask

  // one random text: mostly well formed, some broken, some noise
  task automatic add_text();
    int unsigned pick;
    int unsigned nch;
    bit          ended;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      nch = $urandom_range(1, 8);
      for (int i = 0; i < nch; i++) push_cp(rand_cp(), i == nch - 1);
    end else if (pick < 90) begin
      nch = $urandom_range(0, 3);
      for (int i = 0; i < nch; i++) push_cp(rand_cp(), 1'b0);
      push_broken(ended);
      if (!ended) begin
        nch = $urandom_range(0, 2);
        for (int i = 0; i < nch; i++) push_cp(rand_cp(), 1'b0);
        push_cp(rand_cp(), 1'b1);
      end
    end else begin
      nch = $urandom_range(1, 6);
      for (int i = 0; i < nch; i++) push_byte(8'($urandom_range(0, 255)), i == nch - 1);
    end
  endtask

  task automatic fill(input int unsigned n);
    int unsigned start;
    start = bytes_pushed;
    while (bytes_pushed - start < n) add_text();
  endtask

  // wait until every queued byte is taken and every predicted unit seen
  task automatic drain();
    do @(posedge clk);
    while (bytes_accepted != bytes_pushed || utf16_units_q.size() != 0);
  endtask

  task automatic write_mode(input logic wide);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= wide;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    wide_mode = wide;
  endtask

  // input driver: offers the next queued byte, predicts on each transfer
  always @(posedge clk) begin
    text_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        decode_byte(in_tdata, in_tlast);
        if (in_tlast) n_texts++;
        bytes_accepted++;
      end
      if (text_bytes_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nxt = text_bytes_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.value;
        in_tlast  <= nxt.eot;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // output ready: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (holds_served != hold_req) begin
      holds_served <= hold_req;
      hold_left    <= 300;
      out_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // output monitor: each transfer against the oldest prediction
  always @(posedge clk) begin
    utf16_unit_t want;
    utf16_unit_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen = '{out_tdata[20:0], out_tdata[21], out_tlast, out_tuser};
      n_units++;
      if (seen.err) n_err_results++;
      if (!seen.last_of_byte) n_pairs++;
      if (utf16_units_q.size() == 0) begin
        n_fail++;
        $display("%0t: expected no unit, got code=%h last=%b done=%b err=%b",
                 $realtime, seen.code, seen.last_of_byte, seen.text_done, seen.err);
      end else begin
        want = utf16_units_q.pop_front();
        if (seen.code != want.code || seen.last_of_byte != want.last_of_byte ||
            seen.text_done != want.text_done || seen.err != want.err) begin
          n_fail++;
          $display("%0t: expected code=%h last=%b done=%b err=%b,", $realtime,
                   want.code, want.last_of_byte, want.text_done, want.err);
          $display("    got code=%h last=%b done=%b err=%b",
                   seen.code, seen.last_of_byte, seen.text_done, seen.err);
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b0);

    // directed: field extremes, longest forms, the error paths
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_cp(21'h7FF, 1'b0);
    push_cp(21'h800, 1'b0);
    push_cp(21'hFFFF, 1'b0);
    push_cp(21'h10000, 1'b0);
    push_cp(21'h10FFFF, 1'b1);
    push_byte(8'hC0, 1'b1);          // bad lead on the last byte
    push_byte(8'hF5, 1'b0);          // bad lead, then a dropped byte
    push_byte(8'h41, 1'b1);
    push_byte(8'hE2, 1'b1);          // cut off by the end of the text
    push_byte(LEAD3_SURR, 1'b0);     // surrogate
    push_byte(8'hA0, 1'b1);
    drain();

    // random phases with different mode and back-pressure
    for (int ph = 0; ph < 5; ph++) begin
      repeat (20) @(posedge clk);
      case (ph)
        0: begin write_mode(1'b1); src_idle_pct <= 0;  snk_stall_pct <= 0;  end
        1: begin write_mode(1'b0); src_idle_pct <= 59; snk_stall_pct <= 0;  end
        2: begin write_mode(1'b1); src_idle_pct <= 0;  snk_stall_pct <= 59; end
        3: begin write_mode(1'b0); src_idle_pct <= 17; snk_stall_pct <= 17; end
        default: begin
          write_mode(1'b1);
          src_idle_pct  <= 0;
          snk_stall_pct <= 0;
          hold_req      <= hold_req + 1;
        end
      endcase
      fill(130);
      // sender holds back until the output has caught up
      if (ph == 1) drain();
      fill(130);
      drain();
    end

    repeat (20) @(posedge clk);
    $display("run covered %0d bytes in %0d texts, %0d output units", bytes_accepted,
             n_texts, n_units);
    $display("of which %0d surrogate pairs and %0d error results", n_pairs, n_err_results);
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/utd_pkg.sv
hw/rtl/utd_front.sv
hw/rtl/utd_queue.sv
hw/rtl/utd_back.sv
hw/rtl/utf8_to_utf16_decoder.sv
bench/tb_utf8_to_utf16_decoder.sv
